// File: sv/lla_pkg.sv
package lla_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int LINK_W   = $clog2(CAPACITY + 1);
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 5;
    localparam int CNT_W    = 5;
    localparam int FPOS_W   = 4;
    localparam int STAT_W   = 2;
    localparam int DATA_W   = 32;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);
    localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);

    localparam logic [FUNC_W-1:0] FN_GET    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SET    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] data;
        logic [FPOS_W-1:0]        found_pos;
        logic [CNT_W-1:0]         count;
    } t_rsp;

    typedef struct packed {
        logic              link_we;
        logic [SLOT_W-1:0] link_waddr;
        logic [LINK_W-1:0] link_wdata;
        logic              elem_we;
        logic [DATA_W-1:0] elem_wdata;
    } t_store_wr;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_ACCESS,
        S_INS0,
        S_INS1,
        S_INS2,
        S_RM0,
        S_RM1,
        S_RM2,
        S_SEARCH,
        S_DONE
    } t_state;

endpackage

// File: sv/lla_if.sv
interface lla_req_if import lla_pkg::*; ();
    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lla_rsp_if import lla_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/lla_store.sv
module lla_store import lla_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_store_wr         i_wr,
    input  logic [SLOT_W-1:0] i_link_raddr,
    input  logic [SLOT_W-1:0] i_elem_addr,
    output logic [LINK_W-1:0] o_link_rdata,
    output logic [DATA_W-1:0] o_elem_rdata
);

    logic [LINK_W-1:0] r_link [CAPACITY];
    logic [DATA_W-1:0] r_elem [CAPACITY];

    // slot i chains to slot i+1 out of reset; last slot chains to null
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_link[i] <= LINK_W'(i + 1);
            end
        end else if (i_wr.link_we) begin
            r_link[i_wr.link_waddr] <= i_wr.link_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.elem_we) begin
            r_elem[i_elem_addr] <= i_wr.elem_wdata;
        end
    end

    assign o_link_rdata = r_link[i_link_raddr];
    assign o_elem_rdata = r_elem[i_elem_addr];

endmodule

// File: sv/array_linked_list_engine.sv
// channel  | dir | modport | payload
// i_req    | in  | sink    | func, pos, value
// o_rsp    | out | source  | status, data, found_pos, count
//
// One request at a time: decode, a walk of one link per cycle, then the update
// states (S_ACCESS, S_INS0 to S_INS2 or S_RM0 to S_RM2) and a load of the result register.
// Search walks the list itself in S_SEARCH until a match or the end of the list.
// The walk is limited by the single link read port of the store.
// Link store comes out of reset already chained; no clearing pass.
// A finished result waits in its register; the next request is taken meanwhile.
module array_linked_list_engine import lla_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lla_req_if.sink   i_req,
    lla_rsp_if.source o_rsp
);

    t_state r_state, n_state;

    logic [FUNC_W-1:0]        r_func, n_func;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [LINK_W-1:0]        r_head, n_head;
    logic [LINK_W-1:0]        r_free, n_free;
    logic [CNT_W-1:0]         r_count, n_count;
    logic [LINK_W-1:0]        r_cur, n_cur;
    logic [LINK_W-1:0]        r_tmp, n_tmp;
    logic [CNT_W-1:0]         r_idx, n_idx;
    logic [CNT_W-1:0]         r_tgt, n_tgt;
    logic [STAT_W-1:0]        r_status, n_status;
    logic signed [DATA_W-1:0] r_data, n_data;
    logic [FPOS_W-1:0]        r_fpos, n_fpos;
    logic                     r_out_valid, n_out_valid;
    t_rsp                     r_rsp, n_rsp;

    t_store_wr         wr;
    logic [SLOT_W-1:0] link_raddr;
    logic [SLOT_W-1:0] elem_addr;
    logic [LINK_W-1:0] link_rdata;
    logic [DATA_W-1:0] elem_rdata;

    logic pos_zero;
    logic walk_done;
    logic dec_err;
    logic load;
    logic srch_stop;

    lla_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (wr),
        .i_link_raddr (link_raddr),
        .i_elem_addr  (elem_addr),
        .o_link_rdata (link_rdata),
        .o_elem_rdata (elem_rdata)
    );

    assign pos_zero  = (r_pos == '0);
    assign walk_done = pos_zero || (r_idx == r_tgt) || (r_cur >= NULL_LINK);
    assign load      = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);
    assign srch_stop = (r_cur >= NULL_LINK) || (r_idx == CAP_CNT)
                       || (elem_rdata == r_value);

    always_comb begin
        case (r_func)
            FN_GET, FN_SET, FN_REMOVE: dec_err = (r_pos >= r_count);
            FN_INSERT: dec_err = (r_pos > r_count) || (r_count >= CAP_CNT);
            FN_APPEND: dec_err = (r_count >= CAP_CNT);
            FN_SEARCH: dec_err = 1'b0;
            default:   dec_err = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (dec_err) n_state = S_DONE;
                else if (r_func == FN_SEARCH) n_state = S_SEARCH;
                else n_state = S_WALK;
            end
            S_WALK: begin
                if (walk_done) begin
                    case (r_func)
                        FN_GET, FN_SET:       n_state = S_ACCESS;
                        FN_INSERT, FN_APPEND: n_state = S_INS0;
                        default:              n_state = S_RM0;
                    endcase
                end
            end
            S_ACCESS: n_state = S_DONE;
            S_INS0:   n_state = S_INS1;
            S_INS1:   n_state = S_INS2;
            S_INS2:   n_state = S_DONE;
            S_RM0:    n_state = S_RM1;
            S_RM1:    n_state = S_RM2;
            S_RM2:    n_state = S_DONE;
            S_SEARCH: begin
                if (srch_stop) n_state = S_DONE;
            end
            S_DONE: begin
                if (load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_func      = r_func;
        n_pos       = r_pos;
        n_value     = r_value;
        n_head      = r_head;
        n_free      = r_free;
        n_count     = r_count;
        n_cur       = r_cur;
        n_tmp       = r_tmp;
        n_idx       = r_idx;
        n_tgt       = r_tgt;
        n_status    = r_status;
        n_data      = r_data;
        n_fpos      = r_fpos;
        n_rsp       = r_rsp;
        wr          = '0;
        link_raddr  = r_cur[SLOT_W-1:0];
        elem_addr   = r_cur[SLOT_W-1:0];
        n_out_valid = r_out_valid && !o_rsp.ready;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func   = i_req.payload.func;
                    n_pos    = i_req.payload.pos;
                    n_value  = i_req.payload.value;
                    n_status = ST_OK;
                    n_data   = '0;
                    n_fpos   = '0;
                end
            end
            S_DECODE: begin
                n_cur = r_head;
                n_idx = '0;
                if (r_func == FN_APPEND) begin
                    n_pos = POS_W'(r_count);
                    n_tgt = r_count - CNT_W'(1);
                end else if (r_func == FN_GET || r_func == FN_SET) begin
                    n_tgt = CNT_W'(r_pos);
                end else begin
                    n_tgt = CNT_W'(r_pos) - CNT_W'(1);
                end
                if (dec_err) begin
                    case (r_func)
                        FN_GET, FN_SET, FN_REMOVE: n_status = ST_RANGE;
                        FN_INSERT: n_status = (r_pos > r_count) ? ST_RANGE : ST_FULL;
                        FN_APPEND: n_status = ST_FULL;
                        default:   n_status = ST_OK;
                    endcase
                end
            end
            S_WALK: begin
                if (!walk_done) begin
                    n_cur = link_rdata;
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_ACCESS: begin
                if (r_cur < NULL_LINK) begin
                    n_data = elem_rdata;
                    if (r_func == FN_SET) begin
                        wr.elem_we    = 1'b1;
                        wr.elem_wdata = r_value;
                    end
                end
            end
            S_INS0: begin
                link_raddr    = r_free[SLOT_W-1:0];
                elem_addr     = r_free[SLOT_W-1:0];
                n_tmp         = link_rdata;
                wr.elem_we    = 1'b1;
                wr.elem_wdata = r_value;
            end
            S_INS1: begin
                wr.link_we    = 1'b1;
                wr.link_waddr = r_free[SLOT_W-1:0];
                if (pos_zero) begin
                    wr.link_wdata = r_head;
                    n_head        = r_free;
                end else begin
                    wr.link_wdata = link_rdata;
                end
            end
            S_INS2: begin
                if (!pos_zero) begin
                    wr.link_we    = 1'b1;
                    wr.link_waddr = r_cur[SLOT_W-1:0];
                    wr.link_wdata = r_free;
                end
                n_free  = r_tmp;
                n_count = r_count + CNT_W'(1);
            end
            S_RM0: begin
                n_tmp = pos_zero ? r_head : link_rdata;
            end
            S_RM1: begin
                link_raddr = r_tmp[SLOT_W-1:0];
                elem_addr  = r_tmp[SLOT_W-1:0];
                n_data     = elem_rdata;
                if (pos_zero) begin
                    n_head = link_rdata;
                end else begin
                    wr.link_we    = 1'b1;
                    wr.link_waddr = r_cur[SLOT_W-1:0];
                    wr.link_wdata = link_rdata;
                end
            end
            S_RM2: begin
                wr.link_we    = 1'b1;
                wr.link_waddr = r_tmp[SLOT_W-1:0];
                wr.link_wdata = r_free;
                n_free        = r_tmp;
                n_count       = r_count - CNT_W'(1);
            end
            S_SEARCH: begin
                if (r_cur >= NULL_LINK || r_idx == CAP_CNT) begin
                    n_status = ST_MISS;
                end else if (elem_rdata == r_value) begin
                    n_fpos = r_idx[FPOS_W-1:0];
                end else begin
                    n_cur = link_rdata;
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (load) begin
                    n_out_valid     = 1'b1;
                    n_rsp.status    = r_status;
                    n_rsp.data      = r_data;
                    n_rsp.found_pos = r_fpos;
                    n_rsp.count     = r_count;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= NULL_LINK;
            r_free      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free      <= n_free;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_pos    <= n_pos;
        r_value  <= n_value;
        r_cur    <= n_cur;
        r_tmp    <= n_tmp;
        r_idx    <= n_idx;
        r_tgt    <= n_tgt;
        r_status <= n_status;
        r_data   <= n_data;
        r_fpos   <= n_fpos;
        r_rsp    <= n_rsp;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

`ifndef SYNTH
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("element count above capacity");

    a_head_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_head == NULL_LINK) == (r_count == '0)))
        else $error("head link disagrees with count");

    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_free == NULL_LINK) == (r_count == CAP_CNT)))
        else $error("free list disagrees with count");

    a_err_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_rsp.status != ST_OK) |-> (r_rsp.data == '0))
        else $error("error result carries data");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INS2 && r_state != S_RM2) |=> (r_count == $past(r_count)))
        else $error("count changed outside an update step");
`endif

endmodule

// File: bench/tb_array_linked_list_engine.sv
`timescale 1ns / 1ps

module tb_array_linked_list_engine import lla_pkg::*; ();

    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;
    localparam int IDLE_PCT  = 13;
    localparam int TAIL_WAIT = 40;

    logic i_clk;
    logic i_rst_n;

    lla_req_if req_if ();
    lla_rsp_if rsp_if ();

    array_linked_list_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    logic signed [DATA_W-1:0] list_vals[$];
    t_rsp pending_rsps[$];
    bit   idle_on;
    int   rsp_hold;
    int   errors;
    int   n_sent;
    int   n_checked;
    int   n_full;
    int   n_range;
    int   n_miss;
    t_rsp got_rsp;
    t_rsp want_rsp;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Positional list kept as a plain queue; slot layout is not visible outside.
    function automatic t_rsp predict_rsp(t_req r);
        t_rsp e;
        int   n;
        e = '0;
        n = list_vals.size();
        case (r.func)
            FN_GET, FN_SET: begin
                if (r.pos >= n) begin
                    e.status = ST_RANGE;
                end else begin
                    e.data = list_vals[r.pos];
                    if (r.func == FN_SET) list_vals[r.pos] = r.value;
                end
            end
            FN_INSERT: begin
                if (r.pos > n) e.status = ST_RANGE;
                else if (n >= CAPACITY) e.status = ST_FULL;
                else list_vals.insert(r.pos, r.value);
            end
            FN_APPEND: begin
                if (n >= CAPACITY) e.status = ST_FULL;
                else list_vals.push_back(r.value);
            end
            FN_REMOVE: begin
                if (r.pos >= n) begin
                    e.status = ST_RANGE;
                end else begin
                    e.data = list_vals[r.pos];
                    list_vals.delete(r.pos);
                end
            end
            FN_SEARCH: begin
                e.status = ST_MISS;
                for (int i = 0; i < n; i++) begin
                    if (e.status == ST_MISS && list_vals[i] == r.value) begin
                        e.status    = ST_OK;
                        e.found_pos = FPOS_W'(i);
                    end
                end
            end
            default: ;
        endcase
        e.count = CNT_W'(list_vals.size());
        case (e.status)
            ST_FULL:  n_full++;
            ST_RANGE: n_range++;
            ST_MISS:  n_miss++;
            default: ;
        endcase
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got_v,
                                   logic [DATA_W-1:0] exp_v);
        errors++;
        $display("[%0t] mismatch %0d, %s: got %0h, expected %0h",
                 $realtime, errors, what, got_v, exp_v);
    endtask

    task automatic send_req(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                            logic signed [DATA_W-1:0] value);
        t_req r;
        r.func  = func;
        r.pos   = pos;
        r.value = value;
        @(negedge i_clk);
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do @(posedge i_clk); while (!req_if.ready);
        pending_rsps.push_back(predict_rsp(r));
        n_sent++;
    endtask

    task automatic drain_rsps();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_rsps.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (rsp_hold > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold <= rsp_hold - 1;
        end else begin
            rsp_if.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got_rsp = rsp_if.payload;
            n_checked++;
            if (pending_rsps.size() == 0) begin
                report_mismatch("result with no request pending", got_rsp.data, '0);
            end else begin
                want_rsp = pending_rsps.pop_front();
                if (got_rsp.status !== want_rsp.status)
                    report_mismatch("status", got_rsp.status, want_rsp.status);
                if (got_rsp.data !== want_rsp.data)
                    report_mismatch("data", got_rsp.data, want_rsp.data);
                if (got_rsp.found_pos !== want_rsp.found_pos)
                    report_mismatch("found_pos", got_rsp.found_pos, want_rsp.found_pos);
                if (got_rsp.count !== want_rsp.count)
                    report_mismatch("count", got_rsp.count, want_rsp.count);
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            4, 5:    return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_req(FN_GET, 5'd0, '0);
        send_req(FN_REMOVE, 5'd0, '0);
        send_req(FN_SEARCH, 5'd0, '0);
        send_req(FN_INSERT, 5'd1, 32'sd5);
        drain_rsps();
    endtask

    task automatic test_basic_ops();
        send_req(FN_INSERT, 5'd0, 32'sh7fff_ffff);
        send_req(FN_APPEND, 5'd31, 32'sh8000_0000);
        send_req(FN_INSERT, 5'd1, -32'sd1);
        send_req(FN_SET, 5'd0, 32'sh5a5a_a5a5);
        send_req(FN_SEARCH, 5'd0, -32'sd1);
        send_req(FN_SPARE_6, 5'd31, -32'sd1);
        send_req(FN_SPARE_7, 5'd16, 32'sh8000_0000);
        drain_rsps();
    endtask

    task automatic test_full_list();
        while (list_vals.size() < CAPACITY)
            send_req(FN_APPEND, 5'($urandom_range(0, 31)), pick_value());
        send_req(FN_APPEND, 5'd0, 32'sd1);
        send_req(FN_INSERT, 5'(CAPACITY), 32'sd2);
        drain_rsps();
    endtask

    // Receiver stalls long enough for the result register to fill and the engine to hold off requests.
    task automatic test_backpressure();
        rsp_hold = 150;
        for (int k = 0; k < 8; k++)
            send_req(k[0] ? FN_GET : FN_REMOVE, 5'($urandom_range(0, 3)), pick_value());
        drain_rsps();
    endtask

    task automatic test_random(int n_items);
        logic [FUNC_W-1:0]        func;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        int  n;
        int  pick;
        bit  grow;
        grow = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            idle_on = (k >= n_items / 4);
            n = list_vals.size();
            if (n == CAPACITY) grow = 1'b0;
            else if (n == 0) grow = 1'b1;
            else if ($urandom_range(0, 99) < 3) grow = !grow;
            pick  = $urandom_range(0, 99);
            value = pick_value();
            pos   = 5'($urandom_range(0, 31));
            if (pick < 4) begin
                func = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
            end else if (pick < 10) begin
                func = 3'($urandom_range(0, 5));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < (grow ? 45 : 12)) begin
                    func = $urandom_range(0, 1) ? FN_INSERT : FN_APPEND;
                    pos  = 5'($urandom_range(0, n));
                end else if (pick < 60) begin
                    func = FN_REMOVE;
                    pos  = (n > 0) ? 5'($urandom_range(0, n - 1)) : 5'd0;
                end else if (pick < 85) begin
                    func = $urandom_range(0, 1) ? FN_GET : FN_SET;
                    pos  = (n > 0) ? 5'($urandom_range(0, n - 1)) : 5'd0;
                end else begin
                    func = FN_SEARCH;
                    if (n > 0 && $urandom_range(0, 9) < 7)
                        value = list_vals[$urandom_range(0, n - 1)];
                end
            end
            send_req(func, pos, value);
            if (k == n_items / 2) drain_rsps();
        end
        idle_on = 1'b1;
        drain_rsps();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        idle_on        = 1'b1;
        rsp_hold       = 0;
        errors         = 0;
        n_sent         = 0;
        n_checked      = 0;
        n_full         = 0;
        n_range        = 0;
        n_miss         = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_backpressure();
        test_random(460);

        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("Covered %0d requests, %0d results checked: get/set/insert/append/",
                 n_sent, n_checked);
        $display("remove/search, spare codes, %0d range, %0d full, %0d miss cases.",
                 n_range, n_full, n_miss);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
